@@ rtl/core/xml_text_escape_transcoder_defines.svh @@
// ----------------------------------------------------------------------------
// XML text escape transcoder: assertion macros
// Shared concurrent assertion wrappers; they compile away with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef XML_TEXT_ESCAPE_TRANSCODER_DEFINES_SVH
`define XML_TEXT_ESCAPE_TRANSCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// General property, checked on every rising edge outside reset.
`define XTET_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same-cycle implication built on the general form.
`define XTET_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  `XTET_ASSERT(name, clk, rst_n, (ante) |-> (cons), msg)

`else

`define XTET_ASSERT(name, clk, rst_n, prop, msg)
`define XTET_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/core/xtet_pkg.sv @@
// ----------------------------------------------------------------------------
// XML text escape transcoder package
// Character set codes, job descriptor type and the run expansion tables.
// ----------------------------------------------------------------------------
package xtet_pkg;

  localparam int unsigned CODE_W    = 5;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned RUN_IDX_W = 3;
  localparam int unsigned TEXT_W    = 48;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = FIFO_AW + 1;

  localparam logic [CODE_W-1:0] CODE_NONE      = 5'd0;
  localparam logic [CODE_W-1:0] CODE_ASCII     = 5'd1;
  localparam logic [CODE_W-1:0] CODE_UTF8      = 5'd3;
  localparam logic [CODE_W-1:0] CODE_ISO_FIRST = 5'd4;
  localparam logic [CODE_W-1:0] CODE_ISO_LAST  = 5'd19;
  localparam logic [CODE_W-1:0] CODE_UNKNOWN   = 5'd20;

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_CODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE      = 2'd2;

  localparam logic [BYTE_W-1:0] HIGH_LIMIT = 8'h7F;
  localparam logic [BYTE_W-1:0] LOW_LIMIT  = 8'd30;
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;

  localparam logic [BYTE_W-1:0] CH_AMP  = 8'h26;
  localparam logic [BYTE_W-1:0] CH_QUOT = 8'h22;
  localparam logic [BYTE_W-1:0] CH_APOS = 8'h27;
  localparam logic [BYTE_W-1:0] CH_LT   = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_GT   = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;

  localparam logic [TEXT_W-1:0] TXT_AMP  = {"&amp;", 8'h00};
  localparam logic [TEXT_W-1:0] TXT_QUOT = "&quot;";
  localparam logic [TEXT_W-1:0] TXT_APOS = "&apos;";
  localparam logic [TEXT_W-1:0] TXT_LT   = {"&lt;", 16'h0000};
  localparam logic [TEXT_W-1:0] TXT_GT   = {"&gt;", 16'h0000};
  localparam logic [23:0]       TXT_HEX  = "&#x";

  // Kind of work handed from the front to the back.
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_BYTE = 2'd0;
  localparam kind_t KIND_ENT  = 2'd1;
  localparam kind_t KIND_HEX  = 2'd2;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
  } job_t;

  function automatic logic code_none(input logic [CODE_W-1:0] c);
    return (c == CODE_NONE) || (c >= CODE_UNKNOWN);
  endfunction

  function automatic logic code_narrow(input logic [CODE_W-1:0] c);
    return c inside {CODE_ASCII, [CODE_ISO_FIRST:CODE_ISO_LAST]};
  endfunction

  function automatic logic is_markup(input logic [BYTE_W-1:0] b);
    return b inside {CH_AMP, CH_QUOT, CH_APOS, CH_LT, CH_GT};
  endfunction

  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] n);
    logic [BYTE_W-1:0] w;
    w = {4'h0, n};
    return (n < 4'd10) ? (8'h30 + w) : (8'h57 + w);
  endfunction

  function automatic logic [RUN_IDX_W-1:0] job_len(input job_t j);
    logic [RUN_IDX_W-1:0] len;
    case (j.kind)
      KIND_BYTE: len = 3'd1;
      KIND_ENT: begin
        case (j.data)
          CH_AMP:          len = 3'd5;
          CH_QUOT, CH_APOS: len = 3'd6;
          CH_LT, CH_GT:    len = 3'd4;
          default:         len = 3'd1;
        endcase
      end
      KIND_HEX: len = (j.data[7:4] != 4'h0) ? 3'd6 : 3'd5;
      default:  len = 3'd1;
    endcase
    return len;
  endfunction

  // Whole run of a job, first byte in the top bits.
  function automatic logic [TEXT_W-1:0] job_text(input job_t j);
    logic [TEXT_W-1:0] t;
    case (j.kind)
      KIND_BYTE: t = {j.data, 40'h0};
      KIND_ENT: begin
        case (j.data)
          CH_AMP:  t = TXT_AMP;
          CH_QUOT: t = TXT_QUOT;
          CH_APOS: t = TXT_APOS;
          CH_LT:   t = TXT_LT;
          CH_GT:   t = TXT_GT;
          default: t = {j.data, 40'h0};
        endcase
      end
      KIND_HEX: begin
        if (j.data[7:4] != 4'h0) begin
          t = {TXT_HEX, hex_digit(j.data[7:4]), hex_digit(j.data[3:0]), CH_SEMI};
        end else begin
          t = {TXT_HEX, hex_digit(j.data[3:0]), CH_SEMI, 8'h00};
        end
      end
      default: t = {j.data, 40'h0};
    endcase
    return t;
  endfunction

  function automatic logic [BYTE_W-1:0] job_char(input job_t j,
                                                 input logic [RUN_IDX_W-1:0] idx);
    logic [TEXT_W-1:0] t;
    logic [BYTE_W-1:0] c;
    t = job_text(j);
    case (idx)
      3'd0:    c = t[47:40];
      3'd1:    c = t[39:32];
      3'd2:    c = t[31:24];
      3'd3:    c = t[23:16];
      3'd4:    c = t[15:8];
      3'd5:    c = t[7:0];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/xml_text_escape_transcoder.sv @@
// Path: a result byte passes from the job queue into the registered output stage before it
// is on the output ports; out_pop takes it at an edge where out_empty is low.
// Throughput: one input beat per cycle while each gives at most one byte and out_pop
// keeps up; the back end emits one output byte per cycle unless out_pop holds it back.
// Reset: synchronous, active low; clears configuration, lead state, queue and output stage.
// ----------------------------------------------------------------------------
// XML text escape transcoder
// Escapes XML markup and converts between Latin/ASCII and UTF-8, byte by byte.
// ----------------------------------------------------------------------------
//
// The design is split into a front end and a back end joined by a four-entry
// job queue. The front end holds the configuration registers and the pending
// UTF-8 lead byte, and classifies every accepted beat into a job: a plain byte,
// an XML entity, or a lowercase hex character reference. Beats that produce
// nothing (unsupported code pairs, or a lead byte that waits for its
// continuation) are accepted without queueing anything.
//
// The back end walks each job one byte per cycle, unless out_pop holds the output,
// through a registered output stage, marking the final byte of every run. Because
// the queue sits between them, the input side keeps accepting beats while a long
// entity drains, and it only stalls once the queue has filled.
//
// A configuration write to a valid index clears the pending lead byte. Writes to an index past
// the last register are ignored.

module xml_text_escape_transcoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [xtet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [xtet_pkg::CODE_W-1:0]     cfg_wdata,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [xtet_pkg::BYTE_W-1:0]     in_byte,
  input  logic                            in_string_end,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [xtet_pkg::BYTE_W-1:0]     out_byte,
  output logic                            out_run_last
);
  import xtet_pkg::*;

  // Job handed from the front end into the queue.
  job_t front_job;
  logic front_push;

  // Queue head as seen by the back end.
  job_t q_job;
  logic q_full, q_empty, q_pop;

  xtet_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_byte       (in_byte),
    .in_string_end (in_string_end),
    .job_push      (front_push),
    .job           (front_job),
    .q_full        (q_full)
  );

  xtet_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (front_push),
    .wr_job (front_job),
    .full   (q_full),
    .pop    (q_pop),
    .rd_job (q_job),
    .empty  (q_empty)
  );

  xtet_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_job        (q_job),
    .q_pop        (q_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

endmodule

@@ rtl/core/xtet_front.sv @@
// ----------------------------------------------------------------------------
// XML text escape transcoder: front end
// Holds configuration and lead state, and classifies each input beat.
// ----------------------------------------------------------------------------
`include "xml_text_escape_transcoder_defines.svh"

module xtet_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [xtet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [xtet_pkg::CODE_W-1:0]     cfg_wdata,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [xtet_pkg::BYTE_W-1:0]     in_byte,
  input  logic                            in_string_end,
  output logic                            job_push,
  output xtet_pkg::job_t                  job,
  input  logic                            q_full
);
  import xtet_pkg::*;

  logic [CODE_W-1:0] input_code_r;
  logic [CODE_W-1:0] output_code_r;
  logic              escape_r;
  logic              lead_pending_r, lead_pending_nxt;
  logic [1:0]        lead_low_r, lead_low_nxt;

  logic              accept;
  logic              has_out;
  logic              in_none, out_none, markup, esc_hit;
  logic [BYTE_W-1:0] cont;
  logic              cfg_hit;

  assign accept   = in_push && !q_full;
  assign in_full  = q_full;
  assign job_push = accept && has_out;
  assign cfg_hit  = cfg_we && (cfg_index == CFG_INPUT_CODE || cfg_index == CFG_OUTPUT_CODE ||
                               cfg_index == CFG_ESCAPE);

  always_comb begin
    in_none          = code_none(input_code_r);
    out_none         = code_none(output_code_r);
    markup           = is_markup(in_byte);
    esc_hit          = escape_r && markup;
    cont             = in_byte & CONT_MASK;
    has_out          = 1'b1;
    job.kind         = KIND_BYTE;
    job.data         = in_byte;
    lead_pending_nxt = lead_pending_r;
    lead_low_nxt     = lead_low_r;

    if (lead_pending_r) begin
      // Continuation byte: folded with the stored lead bits, never escaped.
      lead_pending_nxt = 1'b0;
      job.data         = {lead_low_r, cont[5:0]};
    end else if (!escape_r && (in_none || out_none || input_code_r == output_code_r)) begin
      job.data = in_byte;
    end else if (in_none || out_none) begin
      if (markup) begin
        job.kind = KIND_ENT;
      end
    end else if (output_code_r == CODE_UTF8) begin
      if (code_narrow(input_code_r)) begin
        if (esc_hit) begin
          job.kind = KIND_ENT;
        end else if (in_byte > HIGH_LIMIT || in_byte < LOW_LIMIT) begin
          job.kind = KIND_HEX;
        end
      end else if (input_code_r == CODE_UTF8) begin
        if (markup) begin
          job.kind = KIND_ENT;
        end
      end else begin
        has_out = 1'b0;
      end
    end else if (input_code_r == CODE_UTF8 && code_narrow(output_code_r)) begin
      if (esc_hit) begin
        job.kind = KIND_ENT;
      end else if (in_byte > HIGH_LIMIT) begin
        if (in_string_end) begin
          // A lead byte that closes the string folds with zero.
          job.data = {in_byte[1:0], 6'b000000};
        end else begin
          has_out          = 1'b0;
          lead_pending_nxt = 1'b1;
          lead_low_nxt     = in_byte[1:0];
        end
      end
    end else begin
      has_out = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_code_r   <= CODE_NONE;
      output_code_r  <= CODE_NONE;
      escape_r       <= 1'b0;
      lead_pending_r <= 1'b0;
      lead_low_r     <= 2'b00;
    end else if (cfg_hit) begin
      if (cfg_index == CFG_INPUT_CODE) begin
        input_code_r <= cfg_wdata;
      end
      if (cfg_index == CFG_OUTPUT_CODE) begin
        output_code_r <= cfg_wdata;
      end
      if (cfg_index == CFG_ESCAPE) begin
        escape_r <= cfg_wdata[0];
      end
      lead_pending_r <= 1'b0;
    end else if (accept) begin
      lead_pending_r <= lead_pending_nxt;
      lead_low_r     <= lead_low_nxt;
    end
  end

  `XTET_ASSERT_IMP(a_lead_mode, clk, rst_n, lead_pending_r, input_code_r == CODE_UTF8 && code_narrow(output_code_r), "lead byte pending outside the UTF-8 folding mode")

endmodule

@@ rtl/core/xtet_fifo.sv @@
// ----------------------------------------------------------------------------
// XML text escape transcoder: job queue
// Small register queue that decouples classification from expansion.
// ----------------------------------------------------------------------------
`include "xml_text_escape_transcoder_defines.svh"

module xtet_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  xtet_pkg::job_t wr_job,
  output logic           full,
  input  logic           pop,
  output xtet_pkg::job_t rd_job,
  output logic           empty
);
  import xtet_pkg::*;

  job_t               slot_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = (count_r == FIFO_CW'(FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_job  = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_job;
    end
  end

  `XTET_ASSERT_IMP(a_no_overrun, clk, rst_n, push, !full, "job written into a full queue")
  `XTET_ASSERT(a_count_bound, clk, rst_n, count_r <= FIFO_CW'(FIFO_DEPTH), "queue count beyond its depth")

endmodule

@@ rtl/core/xtet_back.sv @@
// ----------------------------------------------------------------------------
// XML text escape transcoder: back end
// Expands each queued job to its byte run, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "xml_text_escape_transcoder_defines.svh"

module xtet_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  xtet_pkg::job_t              q_job,
  output logic                        q_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [xtet_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_run_last
);
  import xtet_pkg::*;

  logic [RUN_IDX_W-1:0] idx_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]    out_byte_r;
  logic                 out_run_last_r;
  logic                 advance, emit, is_last;
  logic [RUN_IDX_W-1:0] len;

  assign len       = job_len(q_job);
  assign is_last   = (idx_r == len - 3'd1);
  assign advance   = !out_valid_r || out_pop;
  assign emit      = advance && !q_empty;
  assign q_pop     = emit && is_last;
  assign out_empty = !out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = out_run_last_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (emit) begin
        idx_r <= is_last ? '0 : idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r     <= job_char(q_job, idx_r);
      out_run_last_r <= is_last;
    end
  end

  `XTET_ASSERT_IMP(a_idle_index, clk, rst_n, q_empty, idx_r == '0, "run index left open with no job queued")
  `XTET_ASSERT_IMP(a_index_in_run, clk, rst_n, !q_empty, idx_r < job_len(q_job), "run index past the end of its job")
  `XTET_ASSERT_IMP(a_run_open, clk, rst_n, out_valid_r && !out_run_last_r, !q_empty, "unfinished run lost its job")

endmodule
